FILE: src/pis_pkg.sv
package pis_pkg;

  localparam int unsigned NUM_VECTORS_DEF = 192;
  localparam int unsigned IDX_W           = 8;
  localparam int unsigned PRIO_W          = 3;
  localparam int unsigned VEC_W           = 8;

  localparam logic [VEC_W-1:0] FIRST_USER_VECTOR = 8'd64;
  localparam logic [VEC_W-1:0] NONE_VECTOR       = 8'd24;

  localparam logic KIND_LINE = 1'b0;
  localparam logic KIND_PRIO = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_LAST = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

endpackage

FILE: src/pis_if.sv
interface pis_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [pis_pkg::IDX_W-1:0]    vector_index;
  logic                         line_level;
  logic [pis_pkg::PRIO_W-1:0]   priority_value;

  modport source (output valid, kind, vector_index, line_level, priority_value,
                  input ready);
  modport sink   (input valid, kind, vector_index, line_level, priority_value,
                  output ready);
endinterface

interface pis_out_if;
  logic                         valid;
  logic                         ready;
  logic [pis_pkg::PRIO_W-1:0]   irq_level;
  logic [pis_pkg::VEC_W-1:0]    cpu_vector;

  modport source (output valid, irq_level, cpu_vector, input ready);
  modport sink   (input valid, irq_level, cpu_vector, output ready);
endinterface

FILE: src/pis_ram.sv
module pis_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/priority_interrupt_selector.sv
// Priority interrupt selector. A priority event (kind 1) stores one 3-bit
// priority and gives no result. A line event (kind 0) sets or clears one
// pending bit and then walks all NUM_VECTORS entries, one per cycle, through a
// single compare unit fed by the priority RAM's read port; it gives one result
// (level, vector index plus 64, or level 0 and vector 24 when nothing is
// pending) after the states SCAN, LAST and DONE, and DONE waits until the
// output register is free. The input is ready only in IDLE, so it is not ready
// during a scan. Ties go to the higher index. Events with an index of
// NUM_VECTORS or more are dropped. A finished result waits in the output
// register, and the next event may be accepted meanwhile.
module priority_interrupt_selector #(
  parameter int unsigned NUM_VECTORS = pis_pkg::NUM_VECTORS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  pis_in_if.sink   in_i,
  pis_out_if.source out_o
);

  localparam int unsigned IW = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

  pis_pkg::state_e state_q, state_d;

  logic [NUM_VECTORS-1:0]        pend_q;
  logic [NUM_VECTORS-1:0]        prio_vld_q;
  logic [IW-1:0]                 cnt_q;

  logic                          s_vld_q;
  logic                          s_pend_q;
  logic                          s_pv_q;
  logic [IW-1:0]                 s_idx_q;

  logic                          found_q;
  logic [pis_pkg::PRIO_W-1:0]    best_lvl_q;
  logic [IW-1:0]                 best_idx_q;

  logic                          out_vld_q;
  logic [pis_pkg::PRIO_W-1:0]    out_lvl_q;
  logic [pis_pkg::VEC_W-1:0]     out_vec_q;

  logic                          in_acc;
  logic                          in_range;
  logic [IW-1:0]                 in_idx;
  logic                          prio_we;
  logic [pis_pkg::PRIO_W-1:0]    ram_rdata;
  logic [pis_pkg::PRIO_W-1:0]    cand;
  logic                          take;
  logic                          out_free;
  logic                          cnt_last;

  assign in_i.ready = (state_q == pis_pkg::ST_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_range   = 32'(in_i.vector_index) < NUM_VECTORS;
  assign in_idx     = in_i.vector_index[IW-1:0];
  assign prio_we    = in_acc && in_range && (in_i.kind == pis_pkg::KIND_PRIO);
  assign cnt_last   = (cnt_q == IW'(NUM_VECTORS - 1));
  assign out_free   = !out_vld_q || out_o.ready;

  pis_ram #(
    .WIDTH (pis_pkg::PRIO_W),
    .DEPTH (NUM_VECTORS)
  ) u_prio_ram (
    .clk_i   (clk_i),
    .we_i    (prio_we),
    .waddr_i (in_idx),
    .wdata_i (in_i.priority_value),
    .re_i    (state_q == pis_pkg::ST_SCAN),
    .raddr_i (cnt_q),
    .rdata_o (ram_rdata)
  );

  // Never-written entries count as priority zero.
  assign cand = s_pv_q ? ram_rdata : '0;
  assign take = s_vld_q && s_pend_q && (cand >= best_lvl_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      pis_pkg::ST_IDLE: begin
        if (in_acc && in_range && (in_i.kind == pis_pkg::KIND_LINE)) begin
          state_d = pis_pkg::ST_SCAN;
        end
      end
      pis_pkg::ST_SCAN: begin
        if (cnt_last) begin
          state_d = pis_pkg::ST_LAST;
        end
      end
      pis_pkg::ST_LAST: state_d = pis_pkg::ST_DONE;
      pis_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = pis_pkg::ST_IDLE;
        end
      end
      default: state_d = pis_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pis_pkg::ST_IDLE;
      pend_q     <= '0;
      prio_vld_q <= '0;
      cnt_q      <= '0;
      s_vld_q    <= 1'b0;
      found_q    <= 1'b0;
      best_lvl_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc && in_range) begin
        if (in_i.kind == pis_pkg::KIND_PRIO) begin
          prio_vld_q[in_idx] <= 1'b1;
        end else begin
          pend_q[in_idx] <= in_i.line_level;
          cnt_q          <= '0;
          found_q        <= 1'b0;
          best_lvl_q     <= '0;
        end
      end

      s_vld_q <= (state_q == pis_pkg::ST_SCAN);
      if (state_q == pis_pkg::ST_SCAN) begin
        cnt_q <= cnt_last ? '0 : cnt_q + IW'(1);
      end

      if (take) begin
        found_q    <= 1'b1;
        best_lvl_q <= cand;
      end

      if (state_q == pis_pkg::ST_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (state_q == pis_pkg::ST_SCAN) begin
      s_idx_q  <= cnt_q;
      s_pend_q <= pend_q[cnt_q];
      s_pv_q   <= prio_vld_q[cnt_q];
    end
    if (take) begin
      best_idx_q <= s_idx_q;
    end
    if (state_q == pis_pkg::ST_DONE && out_free) begin
      out_lvl_q <= best_lvl_q;
      out_vec_q <= found_q ? pis_pkg::VEC_W'(best_idx_q) + pis_pkg::FIRST_USER_VECTOR
                           : pis_pkg::NONE_VECTOR;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.irq_level  = out_lvl_q;
  assign out_o.cpu_vector = out_vec_q;

endmodule
